/* hdl/csm_pkg.sv */
package csm_pkg;

	// stream and configuration port widths
	localparam int TDATA_W     = 40;
	localparam int TUSER_W     = 1;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 60;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MINUTE_MASK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOUR_MASK    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAY_MASK     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MONTH_MASK   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEEKDAY_MASK = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LIMIT = 3'd5;

	localparam logic [15:0] LIMIT_RESET = 16'd10000;

	// command codes
	localparam logic CMD_CHECK  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// calendar limits
	localparam logic [5:0] MINUTE_LAST  = 6'd59;
	localparam logic [4:0] HOUR_LAST    = 5'd23;
	localparam logic [2:0] WEEKDAY_LAST = 3'd6;
	localparam logic [3:0] MONTH_LAST   = 4'd12;
	localparam logic [5:0] MINUTE_SPAN  = 6'd60;
	localparam logic [4:0] HOUR_SPAN    = 5'd24;
	localparam logic [2:0] WEEKDAY_SPAN = 3'd7;

	// reciprocal of 100 scaled by 2^19, exact for 12-bit years
	localparam logic [24:0] RECIP_100 = 25'd5243;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [2:0]  weekday;
	} csm_time_t;

	typedef struct packed {
		logic      cmd;
		csm_time_t tm;
		logic      leap_cur;
		logic      leap_nxt;
	} csm_item_t;

	typedef struct packed {
		logic [59:0] minute_mask;
		logic [23:0] hour_mask;
		logic [30:0] day_mask;
		logic [11:0] month_mask;
		logic [6:0]  weekday_mask;
		logic [15:0] search_limit;
	} csm_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} csm_state_t;

	// gregorian leap year; low product bits below the reciprocal mean a multiple of 100
	function automatic logic leap_year(input logic [11:0] y);
		logic [24:0] prod;
		logic        div4;
		logic        div100;
		logic        div400;
		prod   = 25'(y) * RECIP_100;
		div4   = (y[1:0] == 2'b00);
		div100 = (prod[18:0] < RECIP_100[18:0]);
		div400 = div100 && (prod[20:19] == 2'b00);
		return (div4 && !div100) || div400;
	endfunction

	// days in a month: February 28 or 29, April, June, September and November 30, all other month codes count as 31
	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mo);
		logic [4:0] len;
		unique case (mo)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// all five fields against their masks
	function automatic logic time_match(input csm_cfg_t cfg, input csm_time_t t);
		logic       ok;
		logic [4:0] d_idx;
		logic [3:0] m_idx;
		d_idx = t.day - 5'd1;
		m_idx = t.month - 4'd1;
		ok = (t.day != 5'd0) && (t.month != 4'd0);
		ok = ok && (t.minute < MINUTE_SPAN) && cfg.minute_mask[t.minute];
		ok = ok && (t.hour < HOUR_SPAN) && cfg.hour_mask[t.hour];
		ok = ok && cfg.day_mask[d_idx];
		ok = ok && (m_idx < 4'(MONTH_LAST)) && cfg.month_mask[m_idx];
		ok = ok && (t.weekday < WEEKDAY_SPAN) && cfg.weekday_mask[t.weekday];
		return ok;
	endfunction

endpackage

/* hdl/csm_front.sv */
module csm_front
	import csm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26], weekday[34:32]
	input  logic [TDATA_W-1:0] s_axis_tdata,
	// cmd[0]
	input  logic [TUSER_W-1:0] s_axis_tuser,
	output logic               push,
	output csm_item_t          push_item,
	input  logic               full
);

	logic               valid_s1;
	logic [TDATA_W-1:0] data_s1;
	logic               cmd_s1;
	logic [11:0]        year_nxt;

	assign s_axis_tready = !valid_s1 || !full;
	assign push          = valid_s1 && !full;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
			cmd_s1  <= s_axis_tuser[0];
		end
	end

	// unpack and classify leap years for this year and the next
	assign year_nxt = data_s1[11:0] + 12'd1;

	always_comb begin
		push_item.cmd        = cmd_s1;
		push_item.tm.year    = data_s1[11:0];
		push_item.tm.month   = data_s1[15:12];
		push_item.tm.day     = data_s1[20:16];
		push_item.tm.hour    = data_s1[25:21];
		push_item.tm.minute  = data_s1[31:26];
		push_item.tm.weekday = data_s1[34:32];
		push_item.leap_cur   = leap_year(data_s1[11:0]);
		push_item.leap_nxt   = leap_year(year_nxt);
	end

endmodule

/* hdl/csm_queue.sv */
module csm_queue
	import csm_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  csm_item_t push_item,
	output logic      full,
	input  logic      pop,
	output csm_item_t pop_item,
	output logic      not_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	csm_item_t         entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* hdl/csm_back.sv */
module csm_back
	import csm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  csm_cfg_t           cfg,
	input  logic               item_valid,
	input  csm_item_t          item,
	output logic               pop,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// out_year[11:0], out_month[15:12], out_day[20:16], out_hour[25:21],
	// out_minute[31:26], out_weekday[34:32]
	output logic [TDATA_W-1:0] m_axis_tdata,
	// match_found[0]
	output logic [TUSER_W-1:0] m_axis_tuser
);

	csm_state_t  state_q;
	csm_state_t  state_d;
	csm_time_t   cur_q;
	csm_time_t   nxt;
	csm_time_t   rpt;
	logic        cmd_q;
	logic        found_q;
	logic        leap_cur_q;
	logic        leap_nxt_q;
	logic        yr_adv_q;
	logic        yr_adv;
	logic        leap;
	logic        hit;
	logic        last;
	logic [15:0] cnt_q;
	logic        out_free;
	logic        load_out;
	logic        out_valid_q;
	logic        out_found_q;
	csm_time_t   out_tm_q;

	// advance the working time by one minute
	always_comb begin
		nxt    = cur_q;
		yr_adv = 1'b0;
		leap   = yr_adv_q ? leap_nxt_q : leap_cur_q;
		if (cur_q.minute >= MINUTE_LAST) begin
			nxt.minute = '0;
			if (cur_q.hour >= HOUR_LAST) begin
				nxt.hour    = '0;
				nxt.weekday = (cur_q.weekday >= WEEKDAY_LAST) ? 3'd0 : cur_q.weekday + 3'd1;
				if (cur_q.day >= month_len(leap, cur_q.month)) begin
					nxt.day = 5'd1;
					if (cur_q.month >= MONTH_LAST) begin
						nxt.month = 4'd1;
						nxt.year  = cur_q.year + 12'd1;
						yr_adv    = 1'b1;
					end else begin
						nxt.month = cur_q.month + 4'd1;
					end
				end else begin
					nxt.day = cur_q.day + 5'd1;
				end
			end else begin
				nxt.hour = cur_q.hour + 5'd1;
			end
		end else begin
			nxt.minute = cur_q.minute + 6'd1;
		end
	end

	assign hit      = time_match(cfg, nxt);
	assign last     = ({1'b0, cnt_q} + 17'd1) >= {1'b0, cfg.search_limit};
	assign out_free = !out_valid_q || m_axis_tready;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					pop = 1'b1;
					if (item.cmd == CMD_SEARCH && cfg.search_limit != 16'd0) begin
						state_d = ST_SEARCH;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SEARCH: begin
				if (hit || last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// search counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (pop) begin
			cnt_q <= '0;
		end else if (state_q == ST_SEARCH) begin
			cnt_q <= cnt_q + 16'd1;
		end
	end

	// working time and match flag
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q      <= item.tm;
			cmd_q      <= item.cmd;
			leap_cur_q <= item.leap_cur;
			leap_nxt_q <= item.leap_nxt;
			yr_adv_q   <= 1'b0;
			found_q    <= (item.cmd == CMD_CHECK) ? time_match(cfg, item.tm) : 1'b0;
		end else if (state_q == ST_SEARCH) begin
			cur_q    <= nxt;
			yr_adv_q <= yr_adv_q | yr_adv;
			found_q  <= hit;
		end
	end

	// failed search reports a zero time
	assign rpt = (cmd_q == CMD_SEARCH && !found_q) ? '0 : cur_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_tm_q    <= rpt;
			out_found_q <= found_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = {5'd0, out_tm_q.weekday, out_tm_q.minute, out_tm_q.hour,
		out_tm_q.day, out_tm_q.month, out_tm_q.year};

endmodule

/* hdl/cron_schedule_matcher.sv */
// Cron schedule matcher.
// Software writes one allowed-value mask per cron field (minute, hour, day
// of month, month, weekday) and a search limit over the cfg_we/cfg_index/
// cfg_wdata port while the block is idle. Each input transaction on s_axis
// carries a UTC time in tdata and the command in tuser: check tests the time
// against the masks, search steps forward from the next minute and reports
// the first matching time, or match_found low with a zero time.
// One result transaction per input leaves on m_axis, match_found in tuser.
// Path: an input transaction passes the front input register, a queue entry,
// the back end's working registers and the output register before
// m_axis_tvalid rises. The back end takes one queued item at a time, only
// when idle, and while searching tests one minute per cycle; a search tests
// at most search_limit minutes and stops at the first match.
// Reset clears the queue and the sequencer, zeroes the masks and sets the
// search limit to 10000. When m_axis stalls the result waits in the output
// register, the back end holds its next result, and the queue keeps taking
// input until it fills.
module cron_schedule_matcher
	import csm_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26], weekday[34:32]
	input  logic [TDATA_W-1:0]    s_axis_tdata,
	// cmd[0]
	input  logic [TUSER_W-1:0]    s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_year[11:0], out_month[15:12], out_day[20:16], out_hour[25:21],
	// out_minute[31:26], out_weekday[34:32]
	output logic [TDATA_W-1:0]    m_axis_tdata,
	// match_found[0]
	output logic [TUSER_W-1:0]    m_axis_tuser
);

	csm_cfg_t  cfg_q;
	logic      push;
	csm_item_t push_item;
	logic      full;
	logic      pop;
	csm_item_t pop_item;
	logic      not_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.minute_mask  <= '0;
			cfg_q.hour_mask    <= '0;
			cfg_q.day_mask     <= '0;
			cfg_q.month_mask   <= '0;
			cfg_q.weekday_mask <= '0;
			cfg_q.search_limit <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MINUTE_MASK:  cfg_q.minute_mask  <= cfg_wdata[59:0];
				REG_HOUR_MASK:    cfg_q.hour_mask    <= cfg_wdata[23:0];
				REG_DAY_MASK:     cfg_q.day_mask     <= cfg_wdata[30:0];
				REG_MONTH_MASK:   cfg_q.month_mask   <= cfg_wdata[11:0];
				REG_WEEKDAY_MASK: cfg_q.weekday_mask <= cfg_wdata[6:0];
				REG_SEARCH_LIMIT: cfg_q.search_limit <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	csm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.push_item     (push_item),
		.full          (full)
	);

	csm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (not_empty)
	);

	csm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.item_valid    (not_empty),
		.item          (pop_item),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
